// ===== src/bs3_pkg.sv =====
// bs3_pkg: shared types and constants of the 3x3 box smoothing filter
// no dependencies; used by every module under src but bs3_ram

package bs3_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COL_BITS        = 10;
    localparam int ROW_BITS        = 12;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int DRAIN_BITS      = 11;
    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int RESET_WIDTH     = 1024;
    localparam int RESET_HEIGHT    = 1024;
    localparam int SUM_BITS        = 20;
    localparam int CNT_BITS        = 4;
    localparam int LINE_BITS       = 2 * SAMPLE_BITS;
    localparam int FILL_BITS       = 2;
    localparam logic [FILL_BITS-1:0] FILL_FULL = 2'd2;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 13;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // reciprocal multipliers, result taken from bit RECIP_SHIFT up
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_BITS  = 25;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_ONE   = 25'd16777216;
    localparam logic [RECIP_BITS-1:0] RECIP_THIRD = 25'd5592406;
    localparam logic [RECIP_BITS-1:0] RECIP_NINTH = 25'd1864136;

    typedef struct packed {
        logic                   command;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smoothed;
        logic [COL_BITS-1:0]    out_column;
        logic [ROW_BITS-1:0]    out_row;
        logic                   frame_end;
    } t_out;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0] count;
        logic [COL_BITS-1:0] column;
        logic [ROW_BITS-1:0] row;
        logic                frame_end;
    } t_sum;

    typedef struct packed {
        logic [1:0] count;
        t_sum       res0;
        t_sum       res1;
    } t_push;

    typedef struct packed {
        logic [1:0] count;
        logic       ready;
    } t_q_stat;

endpackage

// ===== src/bs3_ram.sv =====
// bs3_ram: generic single write port, single read port ram with registered read
// no dependencies

module bs3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bs3_window.sv =====
// bs3_window: raster position, line buffer, window registers and window sums
// depends on bs3_pkg and bs3_ram

module bs3_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bs3_pkg::COL_BITS-1:0]  i_w_last,
    input  logic [bs3_pkg::ROW_BITS-1:0]  i_h_last,
    input  logic                          i_valid,
    input  bs3_pkg::t_in                  i_data,
    input  logic                          i_q_ready,
    output logic                          o_ready,
    output logic                          o_draining,
    output bs3_pkg::t_push                o_push
);

    logic [bs3_pkg::COL_BITS-1:0]    r_column, n_column;
    logic [bs3_pkg::ROW_BITS-1:0]    r_row, n_row;
    logic [bs3_pkg::DRAIN_BITS-1:0]  r_drain_col, n_drain_col;
    logic                            r_draining, n_draining;
    logic [bs3_pkg::FILL_BITS-1:0]   r_fill, n_fill;
    logic                            r_rd_ok;
    logic                            r_byp;
    logic [bs3_pkg::LINE_BITS-1:0]   r_byp_data;
    logic [bs3_pkg::SAMPLE_BITS-1:0] r_left0, r_left1, r_up0, r_up1, r_top0, r_top1;
    logic [bs3_pkg::LINE_BITS-1:0]   r_dl, r_dm;

    logic [bs3_pkg::COL_BITS-1:0]    col_c, drain_d, n_dclamp, raddr;
    logic [bs3_pkg::ROW_BITS-1:0]    row_r;
    logic [bs3_pkg::LINE_BITS-1:0]   ram_q, rd, wr_data;
    logic [bs3_pkg::SAMPLE_BITS-1:0] above, two, smp;
    logic                            two_rows, row_ge1, row_ge2, col_ge1, col_ge2;
    logic                            row_end, last_row, drain_last;
    logic                            data_ok, accept, pix_go, drain_go, fill_step, shift_en;
    logic                            byp_hit;
    bs3_pkg::t_sum                   p0, p1, dr;

    function automatic logic [bs3_pkg::SUM_BITS-1:0] col_sum(
        input logic [bs3_pkg::LINE_BITS-1:0] v,
        input logic                          both
    );
        logic [bs3_pkg::SUM_BITS-1:0] acc;
        acc = bs3_pkg::SUM_BITS'(v[bs3_pkg::SAMPLE_BITS-1:0]);
        if (both) begin
            acc = acc + bs3_pkg::SUM_BITS'(v[bs3_pkg::LINE_BITS-1:bs3_pkg::SAMPLE_BITS]);
        end
        return acc;
    endfunction

    // clamp counters against the live frame size
    assign col_c   = (r_column > i_w_last) ? i_w_last : r_column;
    assign row_r   = (r_row > i_h_last) ? i_h_last : r_row;
    assign drain_d = (r_drain_col > bs3_pkg::DRAIN_BITS'(i_w_last)) ? i_w_last
                   : r_drain_col[bs3_pkg::COL_BITS-1:0];

    assign rd    = r_byp ? r_byp_data : ram_q;
    assign above = rd[bs3_pkg::SAMPLE_BITS-1:0];
    assign two   = rd[bs3_pkg::LINE_BITS-1:bs3_pkg::SAMPLE_BITS];
    assign smp   = i_data.sample;

    assign two_rows   = (i_h_last != '0);
    assign row_ge1    = (row_r != '0);
    assign row_ge2    = (row_r > bs3_pkg::ROW_BITS'(1));
    assign col_ge1    = (col_c != '0);
    assign col_ge2    = (col_c > bs3_pkg::COL_BITS'(1));
    assign row_end    = (col_c == i_w_last);
    assign last_row   = (row_r == i_h_last);
    assign drain_last = (drain_d == i_w_last);

    assign data_ok   = r_draining ? (r_fill == bs3_pkg::FILL_FULL) : r_rd_ok;
    assign o_ready   = data_ok && i_q_ready;
    assign accept    = i_valid && o_ready;
    assign pix_go    = accept && (i_data.command == bs3_pkg::CMD_PIXEL) && !r_draining;
    assign drain_go  = accept && (i_data.command == bs3_pkg::CMD_DRAIN) && r_draining;
    assign fill_step = r_draining && (r_fill != bs3_pkg::FILL_FULL) && r_rd_ok && !i_cfg_we;
    assign shift_en  = drain_go || fill_step;
    assign wr_data   = {above, smp};
    assign o_draining = r_draining;

    // window centred one row and one column back
    always_comb begin
        p0.sum   = bs3_pkg::SUM_BITS'(r_left0) + bs3_pkg::SUM_BITS'(smp)
                 + bs3_pkg::SUM_BITS'(r_up0) + bs3_pkg::SUM_BITS'(above);
        p0.count = bs3_pkg::CNT_BITS'(4);
        if (row_ge2) begin
            p0.sum   = p0.sum + bs3_pkg::SUM_BITS'(r_top0) + bs3_pkg::SUM_BITS'(two);
            p0.count = p0.count + bs3_pkg::CNT_BITS'(2);
        end
        if (col_ge2) begin
            p0.sum   = p0.sum + bs3_pkg::SUM_BITS'(r_left1) + bs3_pkg::SUM_BITS'(r_up1);
            p0.count = p0.count + bs3_pkg::CNT_BITS'(2);
            if (row_ge2) begin
                p0.sum   = p0.sum + bs3_pkg::SUM_BITS'(r_top1);
                p0.count = p0.count + bs3_pkg::CNT_BITS'(1);
            end
        end
        p0.column    = col_c - bs3_pkg::COL_BITS'(1);
        p0.row       = row_r - bs3_pkg::ROW_BITS'(1);
        p0.frame_end = 1'b0;
    end

    // last column of the row above, closed at the row end
    always_comb begin
        p1.sum   = bs3_pkg::SUM_BITS'(smp) + bs3_pkg::SUM_BITS'(above);
        p1.count = bs3_pkg::CNT_BITS'(2);
        if (row_ge2) begin
            p1.sum   = p1.sum + bs3_pkg::SUM_BITS'(two);
            p1.count = p1.count + bs3_pkg::CNT_BITS'(1);
        end
        if (col_ge1) begin
            p1.sum   = p1.sum + bs3_pkg::SUM_BITS'(r_left0) + bs3_pkg::SUM_BITS'(r_up0);
            p1.count = p1.count + bs3_pkg::CNT_BITS'(2);
            if (row_ge2) begin
                p1.sum   = p1.sum + bs3_pkg::SUM_BITS'(r_top0);
                p1.count = p1.count + bs3_pkg::CNT_BITS'(1);
            end
        end
        p1.column    = col_c;
        p1.row       = row_r - bs3_pkg::ROW_BITS'(1);
        p1.frame_end = 1'b0;
    end

    // final row: left and middle columns held, right column straight from the ram
    always_comb begin
        dr.sum   = col_sum(r_dm, two_rows);
        dr.count = two_rows ? bs3_pkg::CNT_BITS'(2) : bs3_pkg::CNT_BITS'(1);
        if (drain_d != '0) begin
            dr.sum   = dr.sum + col_sum(r_dl, two_rows);
            dr.count = dr.count + (two_rows ? bs3_pkg::CNT_BITS'(2) : bs3_pkg::CNT_BITS'(1));
        end
        if (!drain_last) begin
            dr.sum   = dr.sum + col_sum(rd, two_rows);
            dr.count = dr.count + (two_rows ? bs3_pkg::CNT_BITS'(2) : bs3_pkg::CNT_BITS'(1));
        end
        dr.column    = drain_d;
        dr.row       = i_h_last;
        dr.frame_end = drain_last;
    end

    always_comb begin
        o_push.count = 2'd0;
        o_push.res0  = p0;
        o_push.res1  = p1;
        if (pix_go) begin
            if (row_ge1 && col_ge1 && row_end) begin
                o_push.count = 2'd2;
            end else if (row_ge1 && col_ge1) begin
                o_push.count = 2'd1;
            end else if (row_ge1 && row_end) begin
                o_push.count = 2'd1;
                o_push.res0  = p1;
            end
        end else if (drain_go) begin
            o_push.count = 2'd1;
            o_push.res0  = dr;
        end
    end

    // next position, drain progress and line buffer read address
    always_comb begin
        n_column    = r_column;
        n_row       = r_row;
        n_drain_col = r_drain_col;
        n_draining  = r_draining;
        n_fill      = r_fill;
        if (pix_go) begin
            if (row_end) begin
                n_column = '0;
                if (last_row) begin
                    n_row       = '0;
                    n_draining  = 1'b1;
                    n_drain_col = '0;
                end else begin
                    n_row = row_r + bs3_pkg::ROW_BITS'(1);
                end
            end else begin
                n_column = col_c + bs3_pkg::COL_BITS'(1);
            end
        end
        if (drain_go) begin
            if (drain_last) begin
                n_draining  = 1'b0;
                n_drain_col = '0;
            end else begin
                n_drain_col = bs3_pkg::DRAIN_BITS'(drain_d) + bs3_pkg::DRAIN_BITS'(1);
            end
        end
        priority if (i_cfg_we) begin
            n_fill = '0;
        end else if (pix_go && row_end && last_row) begin
            n_fill = '0;
        end else if (fill_step) begin
            n_fill = r_fill + bs3_pkg::FILL_BITS'(1);
        end else begin
            n_fill = r_fill;
        end

        n_dclamp = (n_drain_col > bs3_pkg::DRAIN_BITS'(i_w_last)) ? i_w_last
                 : n_drain_col[bs3_pkg::COL_BITS-1:0];
        if (n_draining) begin
            raddr = n_dclamp + bs3_pkg::COL_BITS'(n_fill) - bs3_pkg::COL_BITS'(1);
        end else begin
            raddr = (n_column > i_w_last) ? i_w_last : n_column;
        end
    end

    assign byp_hit = pix_go && (col_c == raddr);

    bs3_ram #(
        .WIDTH (bs3_pkg::LINE_BITS),
        .DEPTH (bs3_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (pix_go),
        .i_waddr (col_c),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row       <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
            r_fill      <= '0;
            r_rd_ok     <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_column    <= n_column;
            r_row       <= n_row;
            r_drain_col <= n_drain_col;
            r_draining  <= n_draining;
            r_fill      <= n_fill;
            r_rd_ok     <= !i_cfg_we;
            r_byp       <= byp_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_data;
        if (pix_go) begin
            r_left1 <= r_left0;
            r_left0 <= smp;
            r_up1   <= r_up0;
            r_up0   <= above;
            r_top1  <= r_top0;
            r_top0  <= two;
        end
        if (shift_en) begin
            r_dl <= r_dm;
            r_dm <= rd;
        end
    end

endmodule

// ===== src/bs3_queue.sv =====
// bs3_queue: two-entry hold for the window sums of one item
// depends on bs3_pkg

module bs3_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bs3_pkg::t_push    i_push,
    input  logic              i_take,
    output logic              o_valid,
    output bs3_pkg::t_sum     o_head,
    output bs3_pkg::t_q_stat  o_stat
);

    logic [1:0]    r_count, n_count;
    bs3_pkg::t_sum r_slot0, r_slot1;
    logic          pop, push;

    assign pop  = (r_count != 2'd0) && i_take;
    assign push = (i_push.count != 2'd0);

    // a new item only lands once the queue is empty or its last entry is taken in that cycle
    assign o_stat.count = r_count;
    assign o_stat.ready = (r_count == 2'd0) || ((r_count == 2'd1) && i_take);
    assign o_valid      = (r_count != 2'd0);
    assign o_head       = r_slot0;

    always_comb begin
        n_count = r_count;
        if (push) begin
            n_count = i_push.count;
        end else if (pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot0 <= i_push.res0;
            r_slot1 <= i_push.res1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

// ===== src/bs3_div.sv =====
// bs3_div: divides a window sum by its neighbour count and holds the result item
// depends on bs3_pkg

module bs3_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bs3_pkg::t_sum  i_data,
    output logic           o_take,
    output logic           o_valid,
    input  logic           i_out_ready,
    output bs3_pkg::t_out  o_data
);

    logic                               r_valid;
    bs3_pkg::t_out                      r_data;
    logic [1:0]                         sh;
    logic [bs3_pkg::RECIP_BITS-1:0]     recip;
    logic [bs3_pkg::SUM_BITS-1:0]       y;
    logic [bs3_pkg::PROD_BITS-1:0]      prod;
    logic [bs3_pkg::SAMPLE_BITS-1:0]    quot;
    logic                               load;

    assign o_take  = !r_valid || i_out_ready;
    assign load    = i_valid && o_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // 6 is a halving then a divide by 3
    always_comb begin
        unique case (i_data.count)
            4'd1:    begin sh = 2'd0; recip = bs3_pkg::RECIP_ONE;   end
            4'd2:    begin sh = 2'd1; recip = bs3_pkg::RECIP_ONE;   end
            4'd3:    begin sh = 2'd0; recip = bs3_pkg::RECIP_THIRD; end
            4'd4:    begin sh = 2'd2; recip = bs3_pkg::RECIP_ONE;   end
            4'd6:    begin sh = 2'd1; recip = bs3_pkg::RECIP_THIRD; end
            4'd9:    begin sh = 2'd0; recip = bs3_pkg::RECIP_NINTH; end
            default: begin sh = 2'd0; recip = '0;                   end
        endcase
        y    = i_data.sum >> sh;
        prod = bs3_pkg::PROD_BITS'(y) * bs3_pkg::PROD_BITS'(recip);
        quot = prod[bs3_pkg::RECIP_SHIFT +: bs3_pkg::SAMPLE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.smoothed   <= quot;
            r_data.out_column <= i_data.column;
            r_data.out_row    <= i_data.row;
            r_data.frame_end  <= i_data.frame_end;
        end
    end

endmodule

// ===== src/box_smooth_3x3.sv =====
// box_smooth_3x3: 3x3 mean filter over a raster stream; top level with config registers
// path: a taken item's sums are registered in the result queue, then divided into the output
// register; throughput: one item per cycle while the output accepts, set by the single
// line-buffer read port; a row-end item with two results holds the input until the queue
// drains, a config write holds it, and the drain holds it until the drain window fills
// reset: synchronous active low, clears control only; line buffer is never cleared

module box_smooth_3x3 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bs3_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [bs3_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bs3_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bs3_pkg::t_out                       o_out_data
);

    logic [bs3_pkg::WIDTH_REG_BITS-1:0]  r_image_width;
    logic [bs3_pkg::HEIGHT_REG_BITS-1:0] r_image_height;
    logic [bs3_pkg::COL_BITS-1:0]        w_last;
    logic [bs3_pkg::ROW_BITS-1:0]        h_last;
    logic                                draining;
    bs3_pkg::t_push                      push;
    bs3_pkg::t_q_stat                    q_stat;
    bs3_pkg::t_sum                       q_head;
    logic                                q_valid;
    logic                                div_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bs3_pkg::WIDTH_REG_BITS'(bs3_pkg::RESET_WIDTH);
            r_image_height <= bs3_pkg::HEIGHT_REG_BITS'(bs3_pkg::RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bs3_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[bs3_pkg::WIDTH_REG_BITS-1:0];
                end
                bs3_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[bs3_pkg::HEIGHT_REG_BITS-1:0];
                end
            endcase
        end
    end

    // last column and row index, zero taken as one and oversize as the maximum
    always_comb begin
        if (r_image_width == '0) begin
            w_last = '0;
        end else if (r_image_width > bs3_pkg::WIDTH_REG_BITS'(bs3_pkg::MAX_WIDTH)) begin
            w_last = bs3_pkg::COL_BITS'(bs3_pkg::MAX_WIDTH - 1);
        end else begin
            w_last = bs3_pkg::COL_BITS'(r_image_width - bs3_pkg::WIDTH_REG_BITS'(1));
        end
        if (r_image_height == '0) begin
            h_last = '0;
        end else if (r_image_height > bs3_pkg::HEIGHT_REG_BITS'(bs3_pkg::MAX_HEIGHT)) begin
            h_last = bs3_pkg::ROW_BITS'(bs3_pkg::MAX_HEIGHT - 1);
        end else begin
            h_last = bs3_pkg::ROW_BITS'(r_image_height - bs3_pkg::HEIGHT_REG_BITS'(1));
        end
    end

    bs3_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_w_last   (w_last),
        .i_h_last   (h_last),
        .i_valid    (i_in_valid),
        .i_data     (i_in_data),
        .i_q_ready  (q_stat.ready),
        .o_ready    (o_in_ready),
        .o_draining (draining),
        .o_push     (push)
    );

    bs3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_take  (div_take),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bs3_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_data      (q_head),
        .o_take      (div_take),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_out_data)
    );

`ifndef ASSERT_OFF
    a_queue_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count != 2'd3)
        else $error("result queue holds more than two entries");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && $past(i_rst_n)) |-> $past(q_stat.count != 2'd0))
        else $error("result item appeared with nothing queued");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(draining) && $past(i_rst_n)) |-> $past(push.count == 2'd1))
        else $error("drain ended without its final result");
`endif

endmodule
